/* sv/tae_pkg.sv */
// Package of types, constants and codes for the transcript abundance EM unit.
`timescale 1ns / 1ps
package tae_pkg;
  localparam int NUM_CLASSES = 256;
  localparam int NUM_TRANSCRIPTS = 32;
  localparam int CW = $clog2(NUM_CLASSES);
  localparam int TW = 5;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_CLASS = 2'd0,
    KIND_LENGTH = 2'd1,
    KIND_RUN = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_LENNORM = 3'd0,
    REG_MAXIT = 3'd1,
    REG_THRESH = 3'd2,
    REG_CLASSES = 3'd3,
    REG_TRANS = 3'd4
  } reg_t;
endpackage

/* sv/tae_div.sv */
// Shared restoring divider, one quotient bit per cycle, 96-bit dividend, zero divisor gives zero.
`timescale 1ns / 1ps
module tae_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [95:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [95:0] quotient
);
  logic [95:0] num;
  logic [63:0] den;
  logic [64:0] rem;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] trial;
  logic [64:0] diff;

  always_comb begin
    trial = {rem[63:0], num[95]};
    diff = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        num <= dividend;
        den <= divisor;
        rem <= '0;
        cnt <= 7'd96;
        quotient <= '0;
      end else if (busy) begin
        if (den == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          quotient <= '0;
        end else begin
          num <= {num[94:0], 1'b0};
          if (!diff[64]) begin
            rem <= diff;
            quotient <= {quotient[94:0], 1'b1};
          end else begin
            rem <= trial;
            quotient <= {quotient[94:0], 1'b0};
          end
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end
endmodule

/* sv/transcript_abundance_em_unit.sv */
// Top level of the transcript abundance EM unit: stores, sequencer and result register.
//  channel   dir  handshake         payload
//  s_axis    in   tvalid/tready     tdata, tuser = kind
//  m_axis    out  tvalid/tready     tdata, tlast
//  apb       in   psel/penable      paddr, pwdata, prdata
// A run first totals the class counts, then per iteration spreads each class count over its
// compatible transcripts and refits the fractions (with an extra weighting and rescaling pass
// under length normalization), each quotient coming from the shared serial divider.
// Reset is synchronous; fractions need no clear since each run initializes all 32.
// s_axis_tready is low during a run; results hold while m_axis_tready is low.
`timescale 1ns / 1ps
module transcript_abundance_em_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: slot_index[7:0], class_count[39:8], compatibility_row[71:40],
  // effective_length[103:72], zero [111:104]
  input  logic [111:0] s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: transcript_index[4:0], estimated_count[52:5], converged[53],
  // iterations_used[69:54], zero [71:70]
  output logic [71:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  typedef enum logic [4:0] {
    S_IDLE, S_TOT, S_INIT, S_RS_RD, S_RS, S_SH_RD, S_SH_DIV, S_SH_ACC, S_SH_MUL,
    S_NF, S_NF_DIV, S_W, S_W_DIV, S_SUMW, S_K, S_NORM, S_NORM_DIV, S_CHK, S_OUT
  } state_t;

  state_t state;
  logic        lennorm;
  logic [15:0] maxit;
  logic [31:0] thresh;
  logic [8:0]  ncls_reg;
  logic [5:0]  ntr_reg;

  logic [31:0] cnt_mem [tae_pkg::NUM_CLASSES];
  logic [31:0] row_mem [tae_pkg::NUM_CLASSES];
  logic [31:0] len_mem [tae_pkg::NUM_TRANSCRIPTS];
  logic [31:0] frac [tae_pkg::NUM_TRANSCRIPTS];
  logic [31:0] prev [tae_pkg::NUM_TRANSCRIPTS];
  logic [31:0] nf [tae_pkg::NUM_TRANSCRIPTS];
  logic [47:0] tcnt [tae_pkg::NUM_TRANSCRIPTS];
  logic [63:0] acc [tae_pkg::NUM_TRANSCRIPTS];
  logic [63:0] wv [tae_pkg::NUM_TRANSCRIPTS];

  logic [8:0]  nc;
  logic [5:0]  nt;
  logic [31:0] tmask;
  logic [15:0] maxit_eff;
  logic [8:0]  ci;
  logic [5:0]  ti;
  logic [15:0] it;
  logic [40:0] total;
  logic [37:0] rs;
  logic [31:0] crow;
  logic [31:0] ccnt;
  logic [63:0] s_sum;
  logic [5:0]  k;
  logic [32:0] pq;
  logic [63:0] prod;
  logic        conv;
  logic        conv_acc;

  logic        dstart;
  logic [95:0] dnum;
  logic [63:0] dden;
  logic        ddone;
  logic [95:0] dq;

  tae_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .dividend(dnum), .divisor(dden),
    .done(ddone), .quotient(dq)
  );

  logic s_acc, m_acc, wr;
  logic [4:0] tsel;
  logic [31:0] dabs;
  logic [47:0] sat_cnt;
  logic [63:0] wsh;
  logic [63:0] ssh;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign tsel = ti[4:0];
  assign s_axis_tready = (state == S_IDLE);
  assign sat_cnt = (acc[tsel] > {16'd0, tae_pkg::MAX48}) ? tae_pkg::MAX48 : acc[tsel][47:0];
  assign dabs = (nf[tsel] > prev[tsel]) ? nf[tsel] - prev[tsel] : prev[tsel] - nf[tsel];
  assign wsh = wv[tsel] >> k;
  assign ssh = s_sum >> k;

  always_comb begin
    unique case (paddr[4:2])
      tae_pkg::REG_LENNORM: prdata = {31'd0, lennorm};
      tae_pkg::REG_MAXIT:   prdata = {16'd0, maxit};
      tae_pkg::REG_THRESH:  prdata = thresh;
      tae_pkg::REG_CLASSES: prdata = {23'd0, ncls_reg};
      tae_pkg::REG_TRANS:   prdata = {26'd0, ntr_reg};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lennorm <= 1'b0;
      maxit <= 16'd1000;
      thresh <= 32'd1074;
      ncls_reg <= 9'd256;
      ntr_reg <= 6'd32;
    end else if (wr) begin
      unique case (paddr[4:2])
        tae_pkg::REG_LENNORM: lennorm <= pwdata[0];
        tae_pkg::REG_MAXIT:   maxit <= pwdata[15:0];
        tae_pkg::REG_THRESH:  thresh <= pwdata;
        tae_pkg::REG_CLASSES: ncls_reg <= pwdata[8:0];
        tae_pkg::REG_TRANS:   ntr_reg <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc && s_axis_tuser == tae_pkg::KIND_CLASS) begin
      cnt_mem[s_axis_tdata[7:0]] <= s_axis_tdata[39:8];
      row_mem[s_axis_tdata[7:0]] <= s_axis_tdata[71:40];
    end
    if (s_acc && s_axis_tuser == tae_pkg::KIND_LENGTH && s_axis_tdata[7:5] == 3'd0)
      len_mem[s_axis_tdata[4:0]] <= s_axis_tdata[103:72];
    if (state == S_TOT || state == S_RS_RD) begin
      ccnt <= cnt_mem[ci[7:0]];
      crow <= row_mem[ci[7:0]] & tmask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      dstart <= 1'b0;
    end else begin
      dstart <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_acc && s_axis_tuser == tae_pkg::KIND_RUN) begin
            nc <= (ncls_reg > 9'd256) ? 9'd256 : ncls_reg;
            nt <= (ntr_reg == 6'd0) ? 6'd1 : ((ntr_reg > 6'd32) ? 6'd32 : ntr_reg);
            tmask <= (ntr_reg == 6'd0) ? 32'd1 : ((ntr_reg >= 6'd32) ? 32'hFFFF_FFFF
                     : ((32'd1 << ntr_reg[4:0]) - 32'd1));
            maxit_eff <= (maxit == 16'd0) ? 16'd1 : maxit;
            total <= '0;
            ci <= '0;
            ti <= '0;
            it <= 16'd1;
            state <= S_TOT;
          end
        end
        S_TOT: begin
          if (ci != 9'd0) total <= total + {9'd0, ccnt};
          if (ci == nc) begin
            state <= S_INIT;
            ti <= '0;
          end else ci <= ci + 9'd1;
          if (ci == 9'd0 && nc == 9'd0) state <= S_INIT;
        end
        S_INIT: begin
          frac[tsel] <= tae_pkg::ONE_Q30;
          prev[tsel] <= '0;
          acc[tsel] <= '0;
          ti <= ti + 6'd1;
          if (ti == 6'd31) begin
            ci <= '0;
            state <= (nc == 9'd0) ? S_NF : S_RS_RD;
            ti <= '0;
          end
        end
        S_RS_RD: begin
          rs <= '0;
          ti <= '0;
          state <= S_RS;
        end
        S_RS: begin
          if (crow[tsel]) rs <= rs + {6'd0, frac[tsel]};
          ti <= ti + 6'd1;
          if (ti == nt - 6'd1) begin
            ti <= '0;
            state <= S_SH_RD;
          end
        end
        S_SH_RD: begin
          if (rs == '0 || ti == nt) begin
            ti <= '0;
            if (ci + 9'd1 == nc) state <= S_NF;
            else state <= S_RS_RD;
            ci <= ci + 9'd1;
          end else if (crow[tsel]) begin
            dnum <= {32'd0, frac[tsel], 32'd0};
            dden <= {26'd0, rs};
            dstart <= 1'b1;
            state <= S_SH_DIV;
          end else ti <= ti + 6'd1;
        end
        S_SH_DIV: begin
          if (ddone) begin
            pq <= dq[32:0];
            state <= S_SH_MUL;
          end
        end
        S_SH_MUL: begin
          prod <= {32'd0, ccnt} * {31'd0, pq};
          state <= S_SH_ACC;
        end
        S_SH_ACC: begin
          acc[tsel] <= acc[tsel] + {16'd0, prod[63:16]};
          ti <= ti + 6'd1;
          state <= S_SH_RD;
        end
        S_NF: begin
          tcnt[tsel] <= sat_cnt;
          dnum <= {34'd0, sat_cnt, 14'd0};
          dden <= {23'd0, total};
          dstart <= 1'b1;
          state <= S_NF_DIV;
        end
        S_NF_DIV: begin
          if (ddone) begin
            nf[tsel] <= (dq[95:32] != '0) ? 32'hFFFF_FFFF : dq[31:0];
            ti <= ti + 6'd1;
            state <= S_NF;
            if (ti == nt - 6'd1) begin
              ti <= '0;
              s_sum <= '0;
              state <= lennorm ? S_W : S_CHK;
              conv_acc <= 1'b1;
            end
          end
        end
        S_W: begin
          dnum <= {56'd0, nf[tsel], 8'd0};
          dden <= {32'd0, len_mem[tsel]};
          dstart <= 1'b1;
          state <= S_W_DIV;
        end
        S_W_DIV: begin
          if (ddone) begin
            wv[tsel] <= dq[63:0];
            s_sum <= s_sum + dq[63:0];
            ti <= ti + 6'd1;
            state <= S_W;
            if (ti == nt - 6'd1) begin
              ti <= '0;
              k <= '0;
              state <= S_K;
            end
          end
        end
        S_K: begin
          if (ssh[63:33] != '0) k <= k + 6'd1;
          else state <= S_NORM;
        end
        S_NORM: begin
          dnum <= {2'd0, wsh, 30'd0};
          dden <= ssh;
          dstart <= 1'b1;
          state <= S_NORM_DIV;
        end
        S_NORM_DIV: begin
          if (ddone) begin
            nf[tsel] <= dq[31:0];
            ti <= ti + 6'd1;
            state <= S_NORM;
            if (ti == nt - 6'd1) begin
              ti <= '0;
              state <= S_CHK;
            end
          end
        end
        S_CHK: begin
          if (ti == nt) begin
            conv <= conv_acc;
            ti <= '0;
            if (!conv_acc) begin
              for (int j = 0; j < tae_pkg::NUM_TRANSCRIPTS; j++)
                if (j < int'(nt)) prev[j] <= nf[j];
            end
            if (conv_acc || it == maxit_eff) begin
              state <= S_OUT;
            end else begin
              it <= it + 16'd1;
              for (int j = 0; j < tae_pkg::NUM_TRANSCRIPTS; j++) acc[j] <= '0;
              ci <= '0;
              state <= (nc == 9'd0) ? S_NF : S_RS_RD;
            end
          end else begin
            if (dabs > thresh) conv_acc <= 1'b0;
            frac[tsel] <= nf[tsel];
            ti <= ti + 6'd1;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_acc) begin
            if (ti == nt) begin
              m_axis_tvalid <= 1'b0;
              state <= S_IDLE;
            end else begin
              m_axis_tvalid <= 1'b1;
              m_axis_tdata <= {2'd0, it, conv, tcnt[tsel], tsel};
              m_axis_tlast <= (ti == nt - 6'd1);
              ti <= ti + 6'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready while results pending");
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> state == S_OUT) else $error("result outside output phase");
  a_last_end: assert property (@(posedge clk) disable iff (rst)
    (m_acc && m_axis_tlast) |=> !m_axis_tvalid) else $error("result after last");
`endif
endmodule
